@@ src/jse_pkg.sv @@
package jse_pkg;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_PAIR,
    KIND_UNI
  } kind_e;

  // One queued run of output characters, as classified by the front end
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  chr;
    logic [15:0] code;
  } run_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned RunIdxW    = 3;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowV   = 8'h76;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLowA   = 8'h61;

  localparam logic [2:0] RunLenPlain = 3'd1;
  localparam logic [2:0] RunLenPair  = 3'd2;
  localparam logic [2:0] RunLenUni   = 3'd6;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = ChZero + {4'd0, nib};
    end else begin
      res = ChLowA + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

@@ src/jse_if.sv @@
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_start;

  modport source (output valid, output in_byte, output string_start, input ready);
  modport sink   (input valid, input in_byte, input string_start, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

@@ src/json_string_escaper.sv @@
// JSON string escaper.
// in_i carries one string byte per item (in_byte, string_start); string_start
// clears any half-decoded UTF-8 sequence before that byte is handled.
// out_o carries the escaped text one character per item, run_last marking
// the final character produced for an input byte (runs of 0 to 6 chars).
// cfg_we_i/cfg_wdata_i write the UTF-8 escape enable (reset value 1).
// Throughput: one input byte per cycle while the run queue has room and one
// output character per cycle while the receiver is ready; a byte giving n
// characters takes n output items. A run's first character is offered once
// the four-entry run queue between front and back holds it at its head.
// Input ready drops only while the run queue is full, so a stalled receiver
// backs up at most four runs before input is held; bytes that produce nothing
// (lead and stray continuation bytes) still need a free slot to be taken.
// Reset empties the queue, clears the decoder state and sets the enable.
module json_string_escaper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  jse_in_if.sink        in_i,
  jse_out_if.source     out_o
);
  import jse_pkg::*;

  logic full, empty, push, pop;
  run_t push_run, head;

  jse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_i.valid),
    .in_byte_i      (in_i.in_byte),
    .string_start_i (in_i.string_start),
    .in_ready_o     (in_i.ready),
    .queue_full_i   (full),
    .push_o         (push),
    .push_run_o     (push_run)
  );

  jse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .run_last_o  (out_o.run_last)
  );

endmodule

@@ src/jse_front.sv @@
module jse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          string_start_i,
  output logic          in_ready_o,
  input  logic          queue_full_i,
  output logic          push_o,
  output jse_pkg::run_t push_run_o
);
  import jse_pkg::*;

  logic        utf8_en_q;
  logic [1:0]  pend_q, pend_d, pend;
  logic [20:0] acc_q, acc_d, acc;
  logic        accept;
  logic        emits;
  logic [20:0] acc_shift;
  logic [1:0]  pend_dec;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && emits;

  assign pend      = string_start_i ? 2'd0 : pend_q;
  assign acc       = string_start_i ? 21'd0 : acc_q;
  assign acc_shift = {acc[14:0], in_byte_i[5:0]};
  assign pend_dec  = pend - 2'd1;

  always_comb begin
    pend_d     = pend;
    acc_d      = acc;
    emits      = 1'b0;
    push_run_o = '{kind: KIND_PLAIN, chr: in_byte_i, code: acc_shift[15:0]};
    if (utf8_en_q && in_byte_i[7]) begin
      if (pend == 2'd0) begin
        // lead byte opens a sequence; a stray continuation is dropped
        if (in_byte_i[7:4] == 4'hF) begin
          pend_d = 2'd3;
          acc_d  = {18'd0, in_byte_i[2:0]};
        end else if (in_byte_i[7:5] == 3'h7) begin
          pend_d = 2'd2;
          acc_d  = {17'd0, in_byte_i[3:0]};
        end else if (in_byte_i[7:6] == 2'h3) begin
          pend_d = 2'd1;
          acc_d  = {16'd0, in_byte_i[4:0]};
        end
      end else begin
        acc_d  = acc_shift;
        pend_d = pend_dec;
        if (pend_dec == 2'd0) begin
          emits           = 1'b1;
          push_run_o.kind = KIND_UNI;
        end
      end
    end else begin
      emits           = 1'b1;
      push_run_o.kind = KIND_PAIR;
      case (in_byte_i)
        ChBslash, ChSlash, ChDquote, ChSquote: push_run_o.chr = in_byte_i;
        ChLf:    push_run_o.chr = ChLowN;
        ChTab:   push_run_o.chr = ChLowT;
        ChVt:    push_run_o.chr = ChLowV;
        ChFf:    push_run_o.chr = ChLowF;
        ChCr:    push_run_o.chr = ChLowR;
        ChBs:    push_run_o.chr = ChLowB;
        ChNul:   push_run_o.chr = ChZero;
        default: push_run_o.kind = KIND_PLAIN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utf8_en_q <= 1'b1;
      pend_q    <= 2'd0;
      acc_q     <= 21'd0;
    end else begin
      if (cfg_we_i) begin
        utf8_en_q <= cfg_wdata_i;
      end
      if (accept) begin
        pend_q <= pend_d;
        acc_q  <= acc_d;
      end
    end
  end

endmodule

@@ src/jse_queue.sv @@
module jse_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jse_pkg::run_t push_run_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jse_pkg::run_t head_o
);
  import jse_pkg::*;

  run_t                   mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == QueueDepth[QueuePtrW:0]);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ src/jse_back.sv @@
module jse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  jse_pkg::run_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          run_last_o
);
  import jse_pkg::*;

  logic [RunIdxW-1:0] idx_q, idx_d;
  logic [2:0]         run_len;
  logic [3:0]         nib;
  logic               take;

  assign out_valid_o = !empty_i;
  assign take        = out_valid_o && out_ready_i;
  assign run_last_o  = (idx_q == run_len - 3'd1);
  assign pop_o       = take && run_last_o;

  always_comb begin
    case (idx_q)
      3'd2:    nib = head_i.code[15:12];
      3'd3:    nib = head_i.code[11:8];
      3'd4:    nib = head_i.code[7:4];
      default: nib = head_i.code[3:0];
    endcase
  end

  always_comb begin
    case (head_i.kind)
      KIND_PLAIN: begin
        run_len    = RunLenPlain;
        out_char_o = head_i.chr;
      end
      KIND_PAIR: begin
        run_len    = RunLenPair;
        out_char_o = (idx_q == 3'd0) ? ChBslash : head_i.chr;
      end
      KIND_UNI: begin
        run_len = RunLenUni;
        case (idx_q)
          3'd0:    out_char_o = ChBslash;
          3'd1:    out_char_o = ChLowU;
          default: out_char_o = hex_char(nib);
        endcase
      end
      default: begin
        run_len    = RunLenPlain;
        out_char_o = head_i.chr;
      end
    endcase
  end

  // advance through the run, restart at the next queued item
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = run_last_o ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import jse_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned SettleCycles = 20;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } esc_char_t;

  // Tracks the UTF-8 decoder and holds the characters still owed by the block
  class escape_scoreboard;
    bit          utf8_on;
    logic [1:0]  seq_left;
    logic [20:0] code_bits;
    esc_char_t   owed_chars[$];
    int          errors;

    function new();
      utf8_on   = 1'b1;
      seq_left  = '0;
      code_bits = '0;
      errors    = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic s);
      string      hex_digits;
      logic [7:0] run[6];
      int         n;
      esc_char_t  ec;
      hex_digits = "0123456789abcdef";
      n = 0;
      if (s) begin
        seq_left  = '0;
        code_bits = '0;
      end
      if (utf8_on && b[7]) begin
        if (seq_left == 2'd0) begin
          // lead byte opens a sequence; continuation with nothing open is dropped
          if (b[7:4] == 4'hF) begin
            seq_left  = 2'd3;
            code_bits = {18'd0, b[2:0]};
          end else if (b[7:5] == 3'b111) begin
            seq_left  = 2'd2;
            code_bits = {17'd0, b[3:0]};
          end else if (b[7:6] == 2'b11) begin
            seq_left  = 2'd1;
            code_bits = {16'd0, b[4:0]};
          end
          return;
        end
        code_bits = {code_bits[14:0], b[5:0]};
        seq_left  = seq_left - 2'd1;
        if (seq_left != 2'd0) return;
        run[0] = ChBslash;
        run[1] = ChLowU;
        run[2] = hex_digits[code_bits[15:12]];
        run[3] = hex_digits[code_bits[11:8]];
        run[4] = hex_digits[code_bits[7:4]];
        run[5] = hex_digits[code_bits[3:0]];
        n = 6;
      end else begin
        run[0] = ChBslash;
        n = 2;
        case (b)
          ChBslash, ChSlash, ChDquote, ChSquote: run[1] = b;
          ChLf:    run[1] = ChLowN;
          ChTab:   run[1] = ChLowT;
          ChVt:    run[1] = ChLowV;
          ChFf:    run[1] = ChLowF;
          ChCr:    run[1] = ChLowR;
          ChBs:    run[1] = ChLowB;
          ChNul:   run[1] = ChZero;
          default: begin
            run[0] = b;
            n = 1;
          end
        endcase
      end
      for (int k = 0; k < n; k++) begin
        ec.chr  = run[k];
        ec.last = (k == n - 1);
        owed_chars = {owed_chars, ec};
      end
    endfunction

    function void check_char(logic [7:0] c, logic l);
      esc_char_t ec;
      if (owed_chars.size() == 0) begin
        $error("out_char: none expected, actual 0x%02h (run_last %0b)", c, l);
        errors++;
        return;
      end
      ec = owed_chars.pop_front();
      if (c !== ec.chr) begin
        $error("out_char: expected 0x%02h, actual 0x%02h", ec.chr, c);
        errors++;
      end
      if (l !== ec.last) begin
        $error("run_last: expected %0b, actual %0b", ec.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  jse_in_if  in_if ();
  jse_out_if out_if ();

  json_string_escaper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  escape_scoreboard sb = new();

  int unsigned cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_token = 0;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the token moves
  initial begin
    int seen_hold;
    int hold_left;
    seen_hold = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != seen_hold) begin
        seen_hold = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_char(out_if.out_char, out_if.run_last);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.string_start <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, s);
  endtask

  // Drop valid, wait for every owed character, then let silent items settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_utf8_enable(input logic v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.utf8_on = v;
  endtask

  function automatic logic [7:0] pick_ascii();
    logic [7:0] c;
    case ($urandom_range(20))
      0:  c = ChBslash;
      1:  c = ChSlash;
      2:  c = ChDquote;
      3:  c = ChSquote;
      4:  c = ChLf;
      5:  c = ChTab;
      6:  c = ChVt;
      7:  c = ChFf;
      8:  c = ChCr;
      9:  c = ChBs;
      10: c = ChNul;
      default: c = 8'($urandom_range(127));
    endcase
    return c;
  endfunction

  task automatic send_segment(output int counted);
    int         r;
    int         len;
    logic       s;
    logic [7:0] lead;
    r = $urandom_range(99);
    s = ($urandom_range(7) == 0);
    counted = 1;
    if (r < 45) begin
      send_byte(pick_ascii(), s);
    end else if (r < 80) begin
      len = $urandom_range(4, 2);
      case (len)
        2:       lead = {3'b110, 5'($urandom_range(31))};
        3:       lead = {4'b1110, 4'($urandom_range(15))};
        default: lead = {4'b1111, 4'($urandom_range(15))};
      endcase
      send_byte(lead, s);
      for (int k = 1; k < len; k++) begin
        send_byte({2'b10, 6'($urandom_range(63))}, 1'b0);
      end
      counted = len;
    end else if (r < 90) begin
      send_byte(8'($urandom), s);
      counted = 1;
    end else begin
      // truncated sequence: the next segment lands in the middle of it
      send_byte({3'b111, 5'($urandom_range(31))}, s);
      send_byte({2'b10, 6'($urandom_range(63))}, 1'b0);
      counted = 2;
    end
  endtask

  task automatic run_phase(input int n, input int snd, input int rcv, input bit hold);
    int sent;
    int c;
    snd_idle_pct = snd;
    rcv_stall_pct <= rcv;
    if (hold) hold_token <= hold_token + 1;
    sent = 0;
    while (sent < n) begin
      send_segment(c);
      sent += c;
    end
    wait_idle();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= 8'h00;
    in_if.string_start <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain, escaped and control characters
    send_byte(8'h41, 1'b1);
    send_byte(ChNul, 1'b0);
    send_byte(ChBslash, 1'b0);
    send_byte(ChSlash, 1'b0);
    send_byte(ChDquote, 1'b0);
    send_byte(ChSquote, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChTab, 1'b0);
    send_byte(ChVt, 1'b0);
    send_byte(ChFf, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChBs, 1'b0);
    send_byte(8'h7F, 1'b0);
    // stray continuation, then 2-, 3- and 4-byte sequences
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // lead inside a sequence, then a new string cutting one short
    send_byte(8'hE2, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h42, 1'b1);

    // escaping switched off in mid-sequence keeps the pending state
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    write_utf8_enable(1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hFF, 1'b0);
    write_utf8_enable(1'b1);
    send_byte(8'hAC, 1'b0);
    wait_idle();

    run_phase(45, 0, 0, 1'b0);
    write_utf8_enable(1'b0);
    run_phase(45, 49, 0, 1'b0);
    write_utf8_enable(1'b1);
    run_phase(45, 0, 49, 1'b1);
    write_utf8_enable(1'b0);
    run_phase(25, 28, 28, 1'b0);
    write_utf8_enable(1'b1);
    run_phase(25, 28, 28, 1'b1);

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/jse_pkg.sv
src/jse_if.sv
src/jse_front.sv
src/jse_queue.sv
src/jse_back.sv
src/json_string_escaper.sv
tb/tb.sv
